// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file of the comment stripper.
// Needs signals named clk and rst in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check b on the same edge where a holds.
`define CCS_ASSERT_NOW(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: a implies b");

// Check b on the edge after the one where a holds.
`define CCS_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: a implies b on the next cycle");

`endif

// ===== hdl/ccs_pkg.sv =====
// Types, character codes and modes for the C comment stripper.
// No dependencies; used by every module of the block.
package ccs_pkg;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_STRING = 2'd1,
    MODE_LINE   = 2'd2,
    MODE_BLOCK  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       out_last;
  } out_item_t;

  typedef struct packed {
    out_item_t r0;
    out_item_t r1;
    logic      two;
  } entry_t;

  typedef struct packed {
    logic full;
    logic head_valid;
  } q_status_t;

endpackage

// ===== hdl/ccs_front.sv =====
// Front part: accepts source bytes, runs the mode tracker and builds queue entries.
// Depends on ccs_pkg.
module ccs_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              text_valid,
  input  ccs_pkg::in_item_t text,
  output logic              text_stall,
  input  ccs_pkg::q_status_t status,
  output logic              push,
  output ccs_pkg::entry_t   entry
);

  ccs_pkg::mode_t mode, mode_next;
  logic slash_pending, slash_next;
  logic star_seen, star_next;
  logic escape_pending, escape_next;
  logic last_out_newline, lon_next;
  logic any_output, ao_next;

  logic [7:0] c;
  logic       last;
  logic       accept;
  logic [2:0] kv;
  logic [7:0] kc [3];
  logic [1:0] n;
  ccs_pkg::out_item_t r0, r1;

  assign c          = text.ch;
  assign last       = text.end_of_text;
  assign text_stall = status.full;
  assign accept     = text_valid && !text_stall;

  // next state of the mode tracker
  always_comb begin
    mode_next   = mode;
    slash_next  = slash_pending;
    star_next   = star_seen;
    escape_next = escape_pending;
    case (mode)
      ccs_pkg::MODE_LINE: begin
        if (c == ccs_pkg::CH_NL) begin
          mode_next   = ccs_pkg::MODE_NORMAL;
          escape_next = 1'b0;
        end
      end
      ccs_pkg::MODE_BLOCK: begin
        if (star_seen && c == ccs_pkg::CH_SLASH) begin
          mode_next   = ccs_pkg::MODE_NORMAL;
          star_next   = 1'b0;
          escape_next = 1'b0;
        end else begin
          star_next = (c == ccs_pkg::CH_STAR);
        end
      end
      ccs_pkg::MODE_STRING: begin
        if (c == ccs_pkg::CH_QUOTE) begin
          if (!escape_pending) mode_next = ccs_pkg::MODE_NORMAL;
          escape_next = 1'b0;
        end else if (c == ccs_pkg::CH_BSLASH) begin
          escape_next = !escape_pending;
        end else begin
          escape_next = 1'b0;
        end
      end
      default: begin
        if (slash_pending && c == ccs_pkg::CH_SLASH) begin
          slash_next = 1'b0;
          mode_next  = ccs_pkg::MODE_LINE;
        end else if (slash_pending && c == ccs_pkg::CH_STAR) begin
          slash_next = 1'b0;
          mode_next  = ccs_pkg::MODE_BLOCK;
          star_next  = 1'b0;
        end else if (c == ccs_pkg::CH_SLASH) begin
          slash_next  = 1'b1;
          escape_next = 1'b0;
        end else begin
          slash_next = 1'b0;
          if (c == ccs_pkg::CH_QUOTE) begin
            if (!escape_pending) mode_next = ccs_pkg::MODE_STRING;
            escape_next = 1'b0;
          end else if (c == ccs_pkg::CH_BSLASH) begin
            escape_next = !escape_pending;
          end else begin
            escape_next = 1'b0;
          end
        end
      end
    endcase
  end

  // candidate bytes: held slash, current byte, slash flushed at end of text
  always_comb begin
    kc[0] = ccs_pkg::CH_SLASH;
    kc[1] = c;
    kc[2] = ccs_pkg::CH_SLASH;
    kv    = 3'b000;
    case (mode)
      ccs_pkg::MODE_LINE:   kv[1] = (c == ccs_pkg::CH_NL);
      ccs_pkg::MODE_BLOCK:  kv[1] = 1'b0;
      ccs_pkg::MODE_STRING: kv[1] = 1'b1;
      default: begin
        if (slash_pending) begin
          kv[0] = (c != ccs_pkg::CH_SLASH) && (c != ccs_pkg::CH_STAR);
          kv[1] = kv[0];
        end else begin
          kv[1] = (c != ccs_pkg::CH_SLASH);
        end
      end
    endcase
    kv[2] = last && slash_next;
  end

  // drop leading and repeated newlines, pack results
  always_comb begin
    ao_next  = any_output;
    lon_next = last_out_newline;
    n        = 2'd0;
    r0       = '0;
    r1       = '0;
    for (int i = 0; i < 3; i++) begin
      if (kv[i] && !(kc[i] == ccs_pkg::CH_NL && (!ao_next || lon_next))) begin
        if (n == 2'd0) begin
          r0.out_char   = kc[i];
          r0.char_valid = 1'b1;
        end else begin
          r1.out_char   = kc[i];
          r1.char_valid = 1'b1;
        end
        n        = n + 2'd1;
        ao_next  = 1'b1;
        lon_next = (kc[i] == ccs_pkg::CH_NL);
      end
    end
    if (last) begin
      if (n == 2'd2) r1.out_last = 1'b1;
      else r0.out_last = 1'b1;
    end
  end

  assign push        = accept && (n != 2'd0 || last);
  assign entry.r0    = r0;
  assign entry.r1    = r1;
  assign entry.two   = (n == 2'd2);

  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      mode             <= ccs_pkg::MODE_NORMAL;
      slash_pending    <= 1'b0;
      star_seen        <= 1'b0;
      escape_pending   <= 1'b0;
      last_out_newline <= 1'b0;
      any_output       <= 1'b0;
    end else if (accept) begin
      mode             <= mode_next;
      slash_pending    <= slash_next;
      star_seen        <= star_next;
      escape_pending   <= escape_next;
      last_out_newline <= lon_next;
      any_output       <= ao_next;
    end
  end

endmodule

// ===== hdl/ccs_queue.sv =====
// Two-entry queue between the front and back parts.
// Depends on ccs_pkg.
module ccs_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ccs_pkg::entry_t    entry,
  input  logic               pop,
  output ccs_pkg::entry_t    head,
  output ccs_pkg::q_status_t status
);

  logic v0, v1, v0_next, v1_next;
  logic slot0_free;
  ccs_pkg::entry_t slot0, slot1;

  assign slot0_free        = pop ? !v1 : !v0;
  assign head              = slot0;
  assign status.head_valid = v0;
  assign status.full       = v1;

  always_comb begin
    v0_next = v0;
    v1_next = v1;
    if (pop) begin
      v0_next = v1;
      v1_next = 1'b0;
    end
    if (push) begin
      if (slot0_free) v0_next = 1'b1;
      else v1_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      v0 <= v0_next;
      v1 <= v1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) slot0 <= slot1;
    if (push) begin
      if (slot0_free) slot0 <= entry;
      else slot1 <= entry;
    end
  end

endmodule

// ===== hdl/ccs_back.sv =====
// Back part: splits queue entries into single items behind an output register.
// Depends on ccs_pkg.
module ccs_back (
  input  logic               clk,
  input  logic               rst,
  input  ccs_pkg::entry_t    head,
  input  ccs_pkg::q_status_t status,
  output logic               pop,
  output logic               clean_valid,
  output ccs_pkg::out_item_t clean,
  input  logic               clean_stall
);

  logic phase;
  logic load;

  assign load = !clean_valid || !clean_stall;
  assign pop  = load && status.head_valid && (!head.two || phase);

  always_ff @(posedge clk) begin
    if (rst) begin
      clean_valid <= 1'b0;
      phase       <= 1'b0;
    end else if (load) begin
      clean_valid <= status.head_valid;
      if (status.head_valid) phase <= head.two && !phase;
    end
  end

  always_ff @(posedge clk) begin
    if (load && status.head_valid) clean <= phase ? head.r1 : head.r0;
  end

endmodule

// ===== hdl/c_comment_stripper_top.sv =====
// C comment stripper, top level: wires the front part, queue and back part.
// Depends on ccs_pkg, ccs_front, ccs_queue, ccs_back.
//
// Input channel text (text_valid / text_stall): one source byte per item, with
// end_of_text on the final byte of a text. Output channel clean (clean_valid /
// clean_stall): one byte of comment-free text per item, or a bare end marker
// (char_valid low) when the final byte brings no byte out; out_last marks the
// final item of each text, after which the stripper starts a fresh text.
// An accepted byte is written into the queue and from there into the output
// register. Throughput: one input byte per cycle while text_stall is low; a
// byte that releases a held slash yields two output items, sent in turn.
// The front part updates the mode tracker once per accepted byte; the rate
// is set by the output register, which moves one item per cycle unless stalled.
// A two-entry queue decouples the parts: while the receiver stalls, the queue
// fills and then text_stall rises; output items and payload hold steady.
// Reset (rst, synchronous) returns to normal mode with no held slash and
// empties the queue and output register.
module c_comment_stripper_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               text_valid,
  input  ccs_pkg::in_item_t  text,
  output logic               text_stall,
  output logic               clean_valid,
  output ccs_pkg::out_item_t clean,
  input  logic               clean_stall
);

  logic               push;
  logic               pop;
  ccs_pkg::entry_t    entry;
  ccs_pkg::entry_t    head;
  ccs_pkg::q_status_t status;

  ccs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text       (text),
    .text_stall (text_stall),
    .status     (status),
    .push       (push),
    .entry      (entry)
  );

  ccs_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .entry  (entry),
    .pop    (pop),
    .head   (head),
    .status (status)
  );

  ccs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .status      (status),
    .pop         (pop),
    .clean_valid (clean_valid),
    .clean       (clean),
    .clean_stall (clean_stall)
  );

endmodule

// ===== hdl/ccs_checker.sv =====
// Port-level checker for the comment stripper, bound to the top level.
// Depends on ccs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ccs_checker (
  input logic               clk,
  input logic               rst,
  input logic               text_valid,
  input ccs_pkg::in_item_t  text,
  input logic               text_stall,
  input logic               clean_valid,
  input ccs_pkg::out_item_t clean,
  input logic               clean_stall
);

  logic text_hs;

  assign text_hs = text_valid && !text_stall;

  `CCS_ASSERT_NOW(a_text_known, text_hs, !$isunknown(text))
  `CCS_ASSERT_NEXT(a_valid_held, clean_valid && clean_stall, clean_valid)
  `CCS_ASSERT_NEXT(a_item_held, clean_valid && clean_stall, $stable(clean))
  `CCS_ASSERT_NOW(a_marker_last, clean_valid && !clean.char_valid, clean.out_last)
  `CCS_ASSERT_NOW(a_marker_zero, clean_valid && !clean.char_valid, clean.out_char == 8'h00)

endmodule

bind c_comment_stripper_top ccs_checker u_ccs_checker (
  .clk         (clk),
  .rst         (rst),
  .text_valid  (text_valid),
  .text        (text),
  .text_stall  (text_stall),
  .clean_valid (clean_valid),
  .clean       (clean),
  .clean_stall (clean_stall)
);
